### rtl/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent property, sampled on the rising clock and disabled in reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

### rtl/mrrh_pkg.sv
`timescale 1ns / 1ps

package mrrh_pkg;

  localparam int unsigned SIZE_W      = 21;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 21'd8192;
  localparam logic [SIZE_W-1:0] STAMP_BYTES = 21'd8;
  localparam int unsigned NS_PER_US   = 1000;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned BUCKET_W    = 10;

  // Result queue depth and the width of counters that must hold the depth itself.
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);

  // Completed message as it leaves the framer.
  typedef struct packed {
    logic        recorded;
    logic [63:0] rtt;
  } token_t;

  // Completed message with its microsecond value.
  typedef struct packed {
    logic        recorded;
    logic [63:0] rtt;
    logic [31:0] us;
  } div_res_t;

  typedef struct packed {
    logic                rtt_recorded;
    logic [63:0]         rtt_ns;
    logic [31:0]         rtt_us;
    logic [BUCKET_W-1:0] bucket_index;
    logic [31:0]         bucket_count;
    logic [63:0]         rtt_count;
    logic [63:0]         sum_rtt_ns;
    logic [31:0]         peak_rtt_us;
    logic [63:0]         message_count;
  } result_t;

  // One byte of long division by 1000: the remainder stays below 1000, so each
  // bit is one shift, compare and subtract on an 11-bit value.
  function automatic logic [REM_W+7:0] div_byte(logic [REM_W-1:0] rem, logic [7:0] bits);
    logic [REM_W:0] r;
    logic [7:0]     q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[REM_W-1:0], bits[i]};
      if (r >= (REM_W+1)'(NS_PER_US)) begin
        q[i] = 1'b1;
        r    = r - (REM_W+1)'(NS_PER_US);
      end
    end
    return {r[REM_W-1:0], q};
  endfunction

endpackage

### rtl/mrrh_in_if.sv
`timescale 1ns / 1ps

interface mrrh_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [63:0] time_ns;

  modport source (output valid, data_byte, time_ns, input ready);
  modport sink   (input valid, data_byte, time_ns, output ready);
endinterface

### rtl/mrrh_out_if.sv
`timescale 1ns / 1ps

interface mrrh_out_if;
  logic        valid;
  logic        ready;
  logic        rtt_recorded;
  logic [63:0] rtt_ns;
  logic [31:0] rtt_us;
  logic [9:0]  bucket_index;
  logic [31:0] bucket_count;
  logic [63:0] rtt_count;
  logic [63:0] sum_rtt_ns;
  logic [31:0] peak_rtt_us;
  logic [63:0] message_count;

  modport source (output valid, rtt_recorded, rtt_ns, rtt_us, bucket_index, bucket_count,
                  rtt_count, sum_rtt_ns, peak_rtt_us, message_count, input ready);
  modport sink   (input valid, rtt_recorded, rtt_ns, rtt_us, bucket_index, bucket_count,
                  rtt_count, sum_rtt_ns, peak_rtt_us, message_count, output ready);
endinterface

### rtl/mrrh_framer.sv
`timescale 1ns / 1ps

module mrrh_framer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mrrh_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                        accept_i,
  input  logic [7:0]                  data_byte_i,
  input  logic [63:0]                 time_ns_i,
  output logic                        completes_o,
  output logic                        tok_valid_o,
  output mrrh_pkg::token_t            tok_o
);

  logic [mrrh_pkg::SIZE_W-1:0] size_q;
  logic [mrrh_pkg::SIZE_W-1:0] offset_q, offset_d;
  logic [63:0]                 stamp_q, stamp_d;
  logic [mrrh_pkg::SIZE_W-1:0] size_eff;
  logic [mrrh_pkg::SIZE_W:0]   offset_inc;
  logic                        stamp_ok;
  logic                        tok_valid_q;
  mrrh_pkg::token_t            tok_q, tok_d;

  assign size_eff    = (size_q < mrrh_pkg::STAMP_BYTES) ? mrrh_pkg::STAMP_BYTES : size_q;
  assign offset_inc  = {1'b0, offset_q} + 22'd1;
  assign completes_o = (offset_inc >= {1'b0, size_eff});

  // The first eight bytes of a message overwrite their lane of the stamp.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      stamp_d[8*b +: 8] = (offset_q == mrrh_pkg::SIZE_W'(b)) ? data_byte_i : stamp_q[8*b +: 8];
    end
  end

  assign offset_d = completes_o ? '0 : offset_inc[mrrh_pkg::SIZE_W-1:0];
  assign stamp_ok = (stamp_d != '0) && (time_ns_i > stamp_d);

  always_comb begin
    tok_d.recorded = stamp_ok;
    tok_d.rtt      = stamp_ok ? (time_ns_i - stamp_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= mrrh_pkg::SIZE_RESET;
      offset_q    <= '0;
      stamp_q     <= '0;
      tok_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        offset_q <= offset_d;
        stamp_q  <= stamp_d;
      end
      tok_valid_q <= accept_i & completes_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && completes_o) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

### rtl/mrrh_div.sv
`timescale 1ns / 1ps

// Divides the round trip by 1000, one byte of the dividend per cycle. The first
// byte is done as the token loads, and res_valid_o rises once all eight bytes are done.
module mrrh_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  mrrh_pkg::token_t   tok_i,
  output logic               res_valid_o,
  output mrrh_pkg::div_res_t res_o
);

  logic [2:0]                 cnt_q;
  logic                       done_q;
  logic [mrrh_pkg::REM_W-1:0] rem_q, step_rem;
  logic [7:0]                 step_bits, step_quo;
  logic [mrrh_pkg::REM_W+7:0] step_res;
  logic [55:0]                dvd_q;
  logic [31:0]                quo_q;
  logic                       rec_q;
  logic [63:0]                rtt_q;

  assign step_rem  = tok_valid_i ? '0 : rem_q;
  assign step_bits = tok_valid_i ? tok_i.rtt[63:56] : dvd_q[55:48];
  assign step_res  = mrrh_pkg::div_byte(step_rem, step_bits);
  assign step_quo  = step_res[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 3'd1);
      if (tok_valid_i) begin
        cnt_q <= 3'd7;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      rem_q <= step_res[mrrh_pkg::REM_W+7:8];
      quo_q <= {24'd0, step_quo};
      dvd_q <= tok_i.rtt[55:0];
      rec_q <= tok_i.recorded;
      rtt_q <= tok_i.rtt;
    end else if (cnt_q != '0) begin
      rem_q <= step_res[mrrh_pkg::REM_W+7:8];
      quo_q <= {quo_q[23:0], step_quo};
      dvd_q <= {dvd_q[47:0], 8'd0};
    end
  end

  assign res_valid_o    = done_q;
  assign res_o.recorded = rec_q;
  assign res_o.rtt      = rtt_q;
  assign res_o.us       = quo_q;

endmodule

### rtl/mrrh_stats.sv
`timescale 1ns / 1ps

// Histogram memory with read-modify-write, plus the running statistics.
// Results come from messages of at least eight bytes, so two updates of the same
// bucket never overlap in the registered read-modify-write.
module mrrh_stats #(
  parameter int unsigned HIST_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  mrrh_pkg::div_res_t res_i,
  output logic               clearing_o,
  output logic               push_o,
  output mrrh_pkg::result_t  push_data_o
);

  localparam int unsigned BW = $clog2(HIST_DEPTH);
  localparam logic [BW-1:0] LAST = BW'(HIST_DEPTH - 1);

  logic [31:0]        mem [HIST_DEPTH];
  logic [31:0]        rdata_q;
  logic               clr_q;
  logic [BW-1:0]      clr_addr_q;
  logic [BW-1:0]      bucket_d, st_bucket_q;
  logic               st_valid_q;
  mrrh_pkg::div_res_t st_q;
  logic               upd;
  logic               mem_we;
  logic [BW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic [31:0]        cnt_inc;
  logic [63:0]        sum_q, sum_d;
  logic [63:0]        rcnt_q, rcnt_d;
  logic [31:0]        max_q, max_d;
  logic [63:0]        msg_q, msg_d;

  assign bucket_d = (res_i.us < 32'(HIST_DEPTH)) ? BW'(res_i.us) : LAST;

  assign upd       = st_valid_q & st_q.recorded;
  assign cnt_inc   = rdata_q + 32'd1;
  assign mem_we    = clr_q | upd;
  assign mem_waddr = clr_q ? clr_addr_q : st_bucket_q;
  assign mem_wdata = clr_q ? '0 : cnt_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (res_valid_i) begin
      rdata_q <= mem[bucket_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      st_q        <= res_i;
      st_bucket_q <= bucket_d;
    end
  end

  assign sum_d  = upd ? (sum_q + st_q.rtt) : sum_q;
  assign rcnt_d = upd ? (rcnt_q + 64'd1) : rcnt_q;
  assign max_d  = (upd && (st_q.us > max_q)) ? st_q.us : max_q;
  assign msg_d  = msg_q + 64'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      st_valid_q <= 1'b0;
      sum_q      <= '0;
      rcnt_q     <= '0;
      max_q      <= '0;
      msg_q      <= '0;
    end else begin
      st_valid_q <= res_valid_i;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + BW'(1);
        if (clr_addr_q == LAST) begin
          clr_q <= 1'b0;
        end
      end
      if (st_valid_q) begin
        sum_q  <= sum_d;
        rcnt_q <= rcnt_d;
        max_q  <= max_d;
        msg_q  <= msg_d;
      end
    end
  end

  assign clearing_o = clr_q;
  assign push_o     = st_valid_q;

  always_comb begin
    push_data_o.rtt_recorded  = st_q.recorded;
    push_data_o.rtt_ns        = st_q.rtt;
    push_data_o.rtt_us        = st_q.us;
    push_data_o.bucket_index  = mrrh_pkg::BUCKET_W'(st_bucket_q);
    push_data_o.bucket_count  = st_q.recorded ? cnt_inc : '0;
    push_data_o.rtt_count     = rcnt_d;
    push_data_o.sum_rtt_ns    = sum_d;
    push_data_o.peak_rtt_us   = max_d;
    push_data_o.message_count = msg_d;
  end

endmodule

### rtl/mrrh_fifo.sv
`timescale 1ns / 1ps

module mrrh_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mrrh_pkg::result_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output mrrh_pkg::result_t head_o
);

  localparam logic [mrrh_pkg::PTR_W-1:0] PTR_LAST = mrrh_pkg::PTR_W'(mrrh_pkg::FIFO_DEPTH - 1);

  mrrh_pkg::result_t            entries [mrrh_pkg::FIFO_DEPTH];
  logic [mrrh_pkg::PTR_W-1:0]   wptr_q, rptr_q;
  logic [mrrh_pkg::CNT_W-1:0]   count_q;
  logic                         do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i & valid_o;
  assign head_o  = entries[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + mrrh_pkg::PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + mrrh_pkg::PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + mrrh_pkg::CNT_W'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - mrrh_pkg::CNT_W'(1);
      end
    end
  end

endmodule

### rtl/message_reframer_rtt_histogram.sv
`timescale 1ns / 1ps

// Round-trip reframer with latency histogram.
// in_i carries one byte of the echoed stream per beat with its arrival time in ns.
// out_o carries one beat per completed message: round trip, bucket and totals.
// cfg_we_i/cfg_wdata_i set the message size in bytes; sizes below 8 act as 8.
// Write it only while no message is in flight.
// Throughput: one byte per cycle while in_i.ready is high. A message completes at most once per 8 bytes.
// The result of a message passes the framer's token register, the byte-per-cycle
// divide by 1000 and the read-modify-write of the histogram memory, and is then
// queued for out_o.
// Reset: all counters, the framing offset and the stamp clear; the histogram
// memory is then cleared one entry per cycle, all HIST_DEPTH entries, during which
// in_i.ready is low.
// Stall: results queue in a 4-entry buffer. Once the clear is done, bytes that do not end
// a message are always taken; a final byte is held off only when 4 results are queued
// or in flight.
module message_reframer_rtt_histogram #(
  parameter int unsigned HIST_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mrrh_pkg::SIZE_W-1:0] cfg_wdata_i,
  mrrh_in_if.sink                     in_i,
  mrrh_out_if.source                  out_o
);

  logic                       in_accept;
  logic                       out_pop;
  logic                       completes;
  logic                       clearing;
  logic                       tok_valid;
  mrrh_pkg::token_t           tok;
  logic                       res_valid;
  mrrh_pkg::div_res_t         res;
  logic                       push;
  mrrh_pkg::result_t          push_data;
  logic                       fifo_valid;
  mrrh_pkg::result_t          head;
  logic [mrrh_pkg::CNT_W-1:0] reserved_q;
  logic                       take_final;

  // A message's last byte reserves a queue slot; popping the result frees it.
  assign in_i.ready = !clearing &&
                      (!completes || (reserved_q < mrrh_pkg::CNT_W'(mrrh_pkg::FIFO_DEPTH)));
  assign in_accept  = in_i.valid & in_i.ready;
  assign take_final = in_accept & completes;
  assign out_pop    = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
    end else if (take_final && !out_pop) begin
      reserved_q <= reserved_q + mrrh_pkg::CNT_W'(1);
    end else if (!take_final && out_pop) begin
      reserved_q <= reserved_q - mrrh_pkg::CNT_W'(1);
    end
  end

  mrrh_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (in_accept),
    .data_byte_i (in_i.data_byte),
    .time_ns_i   (in_i.time_ns),
    .completes_o (completes),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  mrrh_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mrrh_stats #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .clearing_o  (clearing),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mrrh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (out_o.ready),
    .valid_o     (fifo_valid),
    .head_o      (head)
  );

  assign out_o.valid         = fifo_valid;
  assign out_o.rtt_recorded  = head.rtt_recorded;
  assign out_o.rtt_ns        = head.rtt_ns;
  assign out_o.rtt_us        = head.rtt_us;
  assign out_o.bucket_index  = head.bucket_index;
  assign out_o.bucket_count  = head.bucket_count;
  assign out_o.rtt_count     = head.rtt_count;
  assign out_o.sum_rtt_ns    = head.sum_rtt_ns;
  assign out_o.peak_rtt_us   = head.peak_rtt_us;
  assign out_o.message_count = head.message_count;

endmodule

### rtl/mrrh_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrrh_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_rec_i,
  input logic [63:0] out_rtt_ns_i,
  input logic [31:0] out_us_i,
  input logic [31:0] out_bcount_i,
  input logic [31:0] out_max_us_i,
  input logic [63:0] out_msg_count_i
);

  logic         stalled;
  logic [159:0] payload;
  logic         norec_beat;
  logic         rec_beat;
  logic         fields_zero;
  logic         max_ok;

  assign stalled     = out_valid_i && !out_ready_i;
  assign payload     = {out_rtt_ns_i, out_msg_count_i, out_bcount_i};
  assign norec_beat  = out_valid_i && !out_rec_i;
  assign rec_beat    = out_valid_i && out_rec_i;
  assign fields_zero = (out_rtt_ns_i == 64'd0) && (out_us_i == 32'd0) &&
                       (out_bcount_i == 32'd0);
  assign max_ok      = (out_us_i <= out_max_us_i);

  // A result beat stays offered until it is taken.
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_i, "result beat dropped")

  // A stalled result beat keeps its round trip, message count and bucket count.
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, stalled, $stable(payload), "stalled payload changed")

  // A message without a usable stamp reports no round trip and no bucket count.
  `ASSERT_IMP(a_norec_zero, clk_i, rst_ni, norec_beat, fields_zero, "unrecorded beat not zero")

  // The running maximum already includes the round trip just recorded.
  `ASSERT_IMP(a_max_covers, clk_i, rst_ni, rec_beat, max_ok, "maximum below round trip")

endmodule

bind message_reframer_rtt_histogram mrrh_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_rec_i       (out_o.rtt_recorded),
  .out_rtt_ns_i    (out_o.rtt_ns),
  .out_us_i        (out_o.rtt_us),
  .out_bcount_i    (out_o.bucket_count),
  .out_max_us_i    (out_o.peak_rtt_us),
  .out_msg_count_i (out_o.message_count)
);
